[sv/pvs_pkg.sv]
// Shared constants, register indexes and control structs for the pump/valve sequencer.
// No dependencies; every other file uses this package.
package pvs_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam int TICK_CFG_W          = 16;
    localparam int DUTY_W              = 8;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;

    localparam int N_SWITCHES = 2;
    localparam int N_VALVES   = 3;

    // valve / switch slots
    localparam int SW_INSIDE     = 0;
    localparam int SW_OUTSIDE    = 1;
    localparam int VALVE_INSIDE  = 0;
    localparam int VALVE_OUTSIDE = 1;
    localparam int VALVE_TANK    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_TICKS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_DELAY_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_GAP_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_DUTY         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUTY        = 3'd5;

    // reset values
    localparam logic [TICK_CFG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd50;
    localparam logic [TICK_CFG_W-1:0] HIT_TICKS_RST        = 16'd2000;
    localparam logic [TICK_CFG_W-1:0] PUMP_DELAY_TICKS_RST = 16'd1000;
    localparam logic [TICK_CFG_W-1:0] OFF_GAP_TICKS_RST    = 16'd50;
    localparam logic [DUTY_W-1:0]     HIT_DUTY_RST         = 8'd255;
    localparam logic [DUTY_W-1:0]     HOLD_DUTY_RST        = 8'd127;

    typedef struct packed {
        logic close;     // force closed this tick
        logic open_req;  // open if currently closed
        logic hit_en;    // allow hit -> hold transition
    } valve_cmd_t;

    typedef struct packed {
        logic open;
        logic hold;
        logic open_next;
        logic hold_next;
        logic fresh;     // opened on this tick
    } valve_stat_t;

endpackage

[sv/pvs_ifs.sv]
// Valid/ready channel interfaces for tick words in and result words out.
// Depends on pvs_pkg for payload widths.
interface pvs_tick_if;
    logic valid;
    logic ready;
    logic inside_switch_raw;
    logic outside_switch_raw;

    modport source (output valid, inside_switch_raw, outside_switch_raw, input ready);
    modport sink   (input valid, inside_switch_raw, outside_switch_raw, output ready);
endinterface

interface pvs_result_if;
    logic                       valid;
    logic                       ready;
    logic                       pump_on;
    logic [pvs_pkg::DUTY_W-1:0] inside_valve_duty;
    logic [pvs_pkg::DUTY_W-1:0] outside_valve_duty;
    logic [pvs_pkg::DUTY_W-1:0] tank_valve_duty;
    logic                       inside_demand;
    logic                       outside_demand;

    modport source (output valid, pump_on, inside_valve_duty, outside_valve_duty,
                    tank_valve_duty, inside_demand, outside_demand, input ready);
    modport sink   (input valid, pump_on, inside_valve_duty, outside_valve_duty,
                    tank_valve_duty, inside_demand, outside_demand, output ready);
endinterface

[sv/pvs_debounce.sv]
// One switch debouncer: last raw level, saturating stable counter, accepted level.
// Depends on pvs_pkg.
module pvs_debounce #(
    parameter int TIMER_WIDTH = pvs_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic                               sample,
    input  logic                               raw,
    input  logic [pvs_pkg::TICK_CFG_W-1:0]     debounce_ticks,
    output logic                               level_next
);
    import pvs_pkg::*;

    localparam int CW = (TIMER_WIDTH > TICK_CFG_W) ? TIMER_WIDTH : TICK_CFG_W;
    localparam logic [TIMER_WIDTH-1:0] CNT_MAX = '1;

    logic                   prev_reg, prev_next;
    logic                   level_reg;
    logic [TIMER_WIDTH-1:0] cnt_reg, cnt_next, cnt_inc;

    always_comb
    begin
        cnt_inc    = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + TIMER_WIDTH'(1);
        cnt_next   = cnt_inc;
        prev_next  = prev_reg;
        level_next = level_reg;
        // counter keeps aging during the off gap, level and last raw hold
        if (sample)
        begin
            prev_next = raw;
            if (raw != prev_reg)
                cnt_next = '0;
            if (CW'(cnt_next) > CW'(debounce_ticks))
                level_next = raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            level_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            prev_reg  <= prev_next;
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[sv/pvs_valve.sv]
// One valve: open/hold flags and saturating hit-phase counter.
// Depends on pvs_pkg for the command and status structs.
module pvs_valve #(
    parameter int TIMER_WIDTH = pvs_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  pvs_pkg::valve_cmd_t            cmd,
    input  logic [pvs_pkg::TICK_CFG_W-1:0] hit_ticks,
    output pvs_pkg::valve_stat_t           stat
);
    import pvs_pkg::*;

    localparam int CW = (TIMER_WIDTH > TICK_CFG_W) ? TIMER_WIDTH : TICK_CFG_W;
    localparam logic [TIMER_WIDTH-1:0] CNT_MAX = '1;

    logic                   open_reg, open_next;
    logic                   hold_reg, hold_next;
    logic [TIMER_WIDTH-1:0] cnt_reg, cnt_next, cnt_inc;
    logic                   fresh;

    always_comb
    begin
        cnt_inc = cnt_reg;
        if (open_reg && !hold_reg && cnt_reg != CNT_MAX)
            cnt_inc = cnt_reg + TIMER_WIDTH'(1);
        open_next = open_reg;
        hold_next = hold_reg;
        cnt_next  = cnt_inc;
        fresh     = 1'b0;
        if (cmd.close)
        begin
            open_next = 1'b0;
            hold_next = 1'b0;
        end
        else if (cmd.open_req && !open_reg)
        begin
            open_next = 1'b1;
            hold_next = 1'b0;
            cnt_next  = '0;
            fresh     = 1'b1;
        end
        if (cmd.hit_en && open_next && !hold_next && CW'(cnt_next) >= CW'(hit_ticks))
            hold_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            hold_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            open_reg <= open_next;
            hold_reg <= hold_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign stat.open      = open_reg;
    assign stat.hold      = hold_reg;
    assign stat.open_next = open_next;
    assign stat.hold_next = hold_next;
    assign stat.fresh     = fresh;

endmodule

[sv/pump_valve_sequencer_unit.sv]
// Pump/valve sequencer top level: input register, debouncers, valves, pump and
// off-gap control, result register. Depends on pvs_pkg, pvs_ifs, pvs_debounce, pvs_valve.
// A tick word is held in the input register, then processed into the result register,
// all state updating in one step between them. One tick word per cycle unless result stalls.
// Reset (rst_n, async, active low): switches off, valves closed, pump off, no off gap,
// configuration registers back to their defaults, both channel stages empty.
module pump_valve_sequencer_unit #(
    parameter int TIMER_WIDTH = pvs_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [pvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pvs_tick_if.sink                       tick,
    pvs_result_if.source                   result
);
    import pvs_pkg::*;

    localparam int CW = (TIMER_WIDTH > TICK_CFG_W) ? TIMER_WIDTH : TICK_CFG_W;
    localparam logic [TIMER_WIDTH-1:0] CNT_MAX = '1;

    // configuration
    logic [TICK_CFG_W-1:0] debounce_ticks_reg, hit_ticks_reg;
    logic [TICK_CFG_W-1:0] pump_delay_ticks_reg, off_gap_ticks_reg;
    logic [DUTY_W-1:0]     hit_duty_reg, hold_duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_TICKS_RST;
            hit_ticks_reg        <= HIT_TICKS_RST;
            pump_delay_ticks_reg <= PUMP_DELAY_TICKS_RST;
            off_gap_ticks_reg    <= OFF_GAP_TICKS_RST;
            hit_duty_reg         <= HIT_DUTY_RST;
            hold_duty_reg        <= HOLD_DUTY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_wdata[TICK_CFG_W-1:0];
                CFG_HIT_TICKS:        hit_ticks_reg        <= cfg_wdata[TICK_CFG_W-1:0];
                CFG_PUMP_DELAY_TICKS: pump_delay_ticks_reg <= cfg_wdata[TICK_CFG_W-1:0];
                CFG_OFF_GAP_TICKS:    off_gap_ticks_reg    <= cfg_wdata[TICK_CFG_W-1:0];
                CFG_HIT_DUTY:         hit_duty_reg         <= cfg_wdata[DUTY_W-1:0];
                CFG_HOLD_DUTY:        hold_duty_reg        <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage and result stage handshake
    logic                  s1_valid_reg;
    logic [N_SWITCHES-1:0] s1_raw_reg;
    logic                  out_valid_reg;
    logic                  advance, step, in_take;

    assign advance    = !out_valid_reg || result.ready;
    assign step       = s1_valid_reg && advance;
    assign tick.ready = !s1_valid_reg || advance;
    assign in_take    = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_raw_reg[SW_INSIDE]  <= tick.inside_switch_raw;
            s1_raw_reg[SW_OUTSIDE] <= tick.outside_switch_raw;
        end
    end

    // sequencing state
    logic                   running_reg, running_next;
    logic                   waiting_reg, waiting_next;
    logic                   gap_reg, gap_next;
    logic [TIMER_WIDTH-1:0] pwc_reg, pwc_next, pwc_inc;
    logic [TIMER_WIDTH-1:0] gc_reg, gc_next, gc_inc;

    logic [N_SWITCHES-1:0] lvl_next;
    logic [N_VALVES-1:0]   dem_vec;
    valve_cmd_t            vcmd [N_VALVES];
    valve_stat_t           vstat [N_VALVES];

    logic any_demand, anything_on, drive, gap_start, gap_expire, close_all, fresh_any;

    for (genvar s = 0; s < N_SWITCHES; s++)
    begin : g_sw
        pvs_debounce #(.TIMER_WIDTH(TIMER_WIDTH)) u_deb (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (step),
            .sample         (!gap_reg),
            .raw            (s1_raw_reg[s]),
            .debounce_ticks (debounce_ticks_reg),
            .level_next     (lvl_next[s])
        );
    end

    for (genvar v = 0; v < N_VALVES; v++)
    begin : g_valve
        pvs_valve #(.TIMER_WIDTH(TIMER_WIDTH)) u_valve (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .cmd       (vcmd[v]),
            .hit_ticks (hit_ticks_reg),
            .stat      (vstat[v])
        );
    end

    always_comb
    begin
        any_demand  = lvl_next[SW_INSIDE] | lvl_next[SW_OUTSIDE];
        anything_on = running_reg | vstat[VALVE_INSIDE].open | vstat[VALVE_OUTSIDE].open
                    | vstat[VALVE_TANK].open;
        pwc_inc     = (waiting_reg && pwc_reg != CNT_MAX) ? pwc_reg + TIMER_WIDTH'(1) : pwc_reg;
        gc_inc      = (gap_reg && gc_reg != CNT_MAX) ? gc_reg + TIMER_WIDTH'(1) : gc_reg;

        gap_expire = gap_reg && (CW'(gc_inc) >= CW'(off_gap_ticks_reg));
        gap_start  = !gap_reg && !any_demand && anything_on;
        // a zero gap closes everything on the tick that starts it
        close_all  = gap_expire || (gap_start && off_gap_ticks_reg == '0);
        drive      = !gap_reg && any_demand;

        // tank follows any demand, zone valves their own switch
        dem_vec[VALVE_INSIDE]  = lvl_next[SW_INSIDE];
        dem_vec[VALVE_OUTSIDE] = lvl_next[SW_OUTSIDE];
        dem_vec[VALVE_TANK]    = 1'b1;
        for (int v = 0; v < N_VALVES; v++)
        begin
            vcmd[v].close    = close_all || (drive && !dem_vec[v]);
            vcmd[v].open_req = drive && dem_vec[v];
            vcmd[v].hit_en   = drive;
        end
        fresh_any = vstat[VALVE_INSIDE].fresh | vstat[VALVE_OUTSIDE].fresh
                  | vstat[VALVE_TANK].fresh;

        running_next = running_reg;
        waiting_next = waiting_reg;
        pwc_next     = pwc_inc;
        gap_next     = gap_reg;
        gc_next      = gc_inc;
        if (gap_start)
        begin
            running_next = 1'b0;
            gap_next     = 1'b1;
            gc_next      = '0;
        end
        if (close_all)
        begin
            waiting_next = 1'b0;
            gap_next     = 1'b0;
        end
        if (drive)
        begin
            if (fresh_any && !running_reg && !waiting_reg)
            begin
                waiting_next = 1'b1;
                pwc_next     = '0;
            end
            if (waiting_next && CW'(pwc_next) >= CW'(pump_delay_ticks_reg))
            begin
                running_next = 1'b1;
                waiting_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            waiting_reg <= 1'b0;
            gap_reg     <= 1'b0;
            pwc_reg     <= '0;
            gc_reg      <= '0;
        end
        else if (step)
        begin
            running_reg <= running_next;
            waiting_reg <= waiting_next;
            gap_reg     <= gap_next;
            pwc_reg     <= pwc_next;
            gc_reg      <= gc_next;
        end
    end

    // result word
    logic [DUTY_W-1:0] duty_next [N_VALVES];
    logic              pump_on_reg, in_dem_reg, out_dem_reg;
    logic [DUTY_W-1:0] in_duty_reg, out_duty_reg, tank_duty_reg;

    always_comb
    begin
        for (int v = 0; v < N_VALVES; v++)
        begin
            if (!vstat[v].open_next)
                duty_next[v] = '0;
            else if (vstat[v].hold_next)
                duty_next[v] = hold_duty_reg;
            else
                duty_next[v] = hit_duty_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pump_on_reg   <= running_next;
            in_duty_reg   <= duty_next[VALVE_INSIDE];
            out_duty_reg  <= duty_next[VALVE_OUTSIDE];
            tank_duty_reg <= duty_next[VALVE_TANK];
            in_dem_reg    <= lvl_next[SW_INSIDE];
            out_dem_reg   <= lvl_next[SW_OUTSIDE];
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.pump_on            = pump_on_reg;
    assign result.inside_valve_duty  = in_duty_reg;
    assign result.outside_valve_duty = out_duty_reg;
    assign result.tank_valve_duty    = tank_duty_reg;
    assign result.inside_demand      = in_dem_reg;
    assign result.outside_demand     = out_dem_reg;

`ifndef SYNTHESIS
    a_run_not_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> !gap_reg)
        else $error("pump running during off gap");

    a_run_not_wait: assert property (@(posedge clk) disable iff (!rst_n)
        !(running_reg && waiting_reg))
        else $error("pump both running and waiting");

    a_step_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed tick produced no result word");

    a_tank_hold_open: assert property (@(posedge clk) disable iff (!rst_n)
        vstat[VALVE_TANK].hold |-> vstat[VALVE_TANK].open)
        else $error("tank valve holding while closed");
`endif

endmodule
